>>> hdl/symmetric_difference_engine_macros.svh
// Assertion macros for the symmetric difference engine.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef SYMMETRIC_DIFFERENCE_ENGINE_MACROS_SVH
`define SYMMETRIC_DIFFERENCE_ENGINE_MACROS_SVH

// checked only outside reset
`define SDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/sde_pkg.sv
// Shared constants for the symmetric difference engine.
// No dependencies.
package sde_pkg;

  localparam int VALUE_W = 32;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

>>> hdl/symmetric_difference_engine.sv
// channel | dir | tdata         | tuser                    | tlast
// s_*     | in  | value[31:0]   | cmd[1:0]                 | -
// m_*     | out | result[31:0]  | [0] empty_res [1] overflow | last
//
// A load item is written straight into its list memory, or dropped if that list is full.
// A finish walks each list element: fetch (ELEM, CAP), then a scan over
// max(index, other list count) entries through the single read port of each
// memory, then TAIL and DECIDE to close; the walk waits while the output
// stalls. s_tready is low for the whole finish.
// Reset clears counts and control only; the list memories need no clearing.
// Top level of the symmetric difference engine; uses sde_pkg and the macro header.
`include "symmetric_difference_engine_macros.svh"

module symmetric_difference_engine
  import sde_pkg::*;
#(
  parameter int LIST_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] value
  input  logic [1:0]   s_tuser,   // [1:0] cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // [31:0] result_value
  output logic [1:0]   m_tuser,   // [0] empty_res, [1] overflow
  output logic         m_tlast
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ELEM   = 3'd1;
  localparam logic [2:0] ST_CAP    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  value_t mem_a [LIST_DEPTH];
  value_t mem_b [LIST_DEPTH];
  value_t rd_a, rd_b;

  logic [2:0]    state;
  logic [CW-1:0] cnt_a, cnt_b;
  logic          dropped;
  logic          phase;      // 0: walking list one, 1: list two
  logic [CW-1:0] idx;
  logic [CW-1:0] scan_j;
  logic [CW-1:0] scan_n;
  logic [AW-1:0] jd;
  logic          dv;
  logic          hit;
  value_t        cur;
  logic          pend_v;
  value_t        pend;

  logic          s_acc;
  logic          out_free;
  logic          load_out;
  value_t        out_val;
  logic          out_last, out_empty;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] own_cnt, oth_cnt, scan_len;
  value_t        own_rd, oth_rd;
  logic          match;

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign own_cnt  = phase ? cnt_b : cnt_a;
  assign oth_cnt  = phase ? cnt_a : cnt_b;
  assign own_rd   = phase ? rd_b : rd_a;
  assign oth_rd   = phase ? rd_a : rd_b;
  assign scan_len = (idx > oth_cnt) ? idx : oth_cnt;
  assign rd_addr  = (state == ST_SCAN) ? scan_j[AW-1:0] : idx[AW-1:0];

  // earlier copy in own list, or present in the other list
  assign match = ((CW'(jd) < idx) && (own_rd == cur)) ||
                 ((CW'(jd) < oth_cnt) && (oth_rd == cur));

  // list memories: writes only while idle; the read registers load every cycle
  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == CMD_LOAD_A && cnt_a < CW'(LIST_DEPTH)) begin
      mem_a[cnt_a[AW-1:0]] <= s_tdata;
    end
    if (s_acc && s_tuser == CMD_LOAD_B && cnt_b < CW'(LIST_DEPTH)) begin
      mem_b[cnt_b[AW-1:0]] <= s_tdata;
    end
    rd_a <= mem_a[rd_addr];
    rd_b <= mem_b[rd_addr];
  end

  // what goes into the output register this cycle
  always_comb begin
    load_out  = 1'b0;
    out_val   = pend;
    out_last  = 1'b0;
    out_empty = 1'b0;
    unique case (state)
      ST_DECIDE: begin
        load_out = !hit && pend_v && out_free;
      end
      ST_DONE: begin
        load_out  = out_free;
        out_last  = 1'b1;
        out_empty = !pend_v;
        out_val   = pend_v ? pend : '0;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt_a   <= '0;
      cnt_b   <= '0;
      dropped <= 1'b0;
      phase   <= 1'b0;
      idx     <= '0;
      scan_j  <= '0;
      dv      <= 1'b0;
      hit     <= 1'b0;
      pend_v  <= 1'b0;
    end else begin
      dv <= (state == ST_SCAN);
      if (state == ST_CAP) begin
        hit <= 1'b0;
      end else if (dv && match) begin
        hit <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            priority if (s_tuser == CMD_LOAD_A) begin
              if (cnt_a < CW'(LIST_DEPTH)) cnt_a <= cnt_a + 1'b1;
              else                         dropped <= 1'b1;
            end else if (s_tuser == CMD_LOAD_B) begin
              if (cnt_b < CW'(LIST_DEPTH)) cnt_b <= cnt_b + 1'b1;
              else                         dropped <= 1'b1;
            end else if (s_tuser == CMD_FINISH) begin
              phase <= 1'b0;
              idx   <= '0;
              state <= ST_ELEM;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_ELEM: begin
          if (idx < own_cnt) begin
            state <= ST_CAP;
          end else if (!phase) begin
            phase <= 1'b1;
            idx   <= '0;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_CAP: begin
          scan_j <= '0;
          state  <= (scan_len == '0) ? ST_DECIDE : ST_SCAN;
        end
        ST_SCAN: begin
          scan_j <= scan_j + 1'b1;
          if (scan_j == scan_n - 1'b1) state <= ST_TAIL;
        end
        ST_TAIL: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (hit) begin
            idx   <= idx + 1'b1;
            state <= ST_ELEM;
          end else if (!pend_v || out_free) begin
            pend_v <= 1'b1;
            idx    <= idx + 1'b1;
            state  <= ST_ELEM;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            pend_v  <= 1'b0;
            cnt_a   <= '0;
            cnt_b   <= '0;
            dropped <= 1'b0;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    jd <= scan_j[AW-1:0];
    if (state == ST_CAP) begin
      cur    <= own_rd;
      scan_n <= scan_len;
    end
    if (state == ST_DECIDE && !hit && (!pend_v || out_free)) begin
      pend <= cur;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= out_val;
      m_tlast <= out_last;
      m_tuser <= {dropped, out_empty};
    end
  end

  `SDE_ASSERT(a_cnt_range, (cnt_a <= CW'(LIST_DEPTH)) && (cnt_b <= CW'(LIST_DEPTH)), "list count beyond depth")
  `SDE_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE && !m_tvalid && !pend_v), "not idle after reset")
  `SDE_ASSERT(a_pend_in_finish, pend_v |-> (state != ST_IDLE), "pending result left after finish")
  `SDE_ASSERT(a_empty_is_last, (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == '0), "empty result malformed")
  `SDE_ASSERT(a_done_clears, (state == ST_DONE && out_free) |=> (cnt_a == '0 && cnt_b == '0 && !dropped), "finish did not clear job state")

endmodule
